// File: hw/rtl/page_run_allocator_top_defines.svh
// assertion macros shared by the page run allocator rtl
`ifndef PAGE_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_RUN_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRA_ASSERT_ANY(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRA_ASSERT(lbl, clk, rst, prop, msg)
`define PRA_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/pra_pkg.sv
// shared types and constants of the page run allocator
`timescale 1ns / 1ps
package pra_pkg;
   localparam int DEF_MAX_PAGES = 1024;
   localparam int DEF_FLAG_BITS = 32;

   typedef enum logic [2:0] {
      ACT_ALLOC = 3'd0,
      ACT_FREE  = 3'd1,
      ACT_SET   = 3'd2,
      ACT_QUERY = 3'd3,
      ACT_RANGE = 3'd4
   } act_type;

   typedef enum logic [1:0] {
      NXT_READ  = 2'd0,
      NXT_WRITE = 2'd1,
      NXT_DONE  = 2'd2
   } next_type;

   typedef struct packed {
      logic clr_en;
      logic latch;
      logic rd;
      logic ev;
      logic wr;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic     cfg_wr;
      logic     clr_last;
      logic     quick;
      next_type ev_next;
      logic     wr_last;
      logic     rsp_busy;
   } status_type;
endpackage

// File: hw/rtl/pra_ctrl.sv
// sequencer of the page run allocator
`timescale 1ns / 1ps
module pra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pra_pkg::status_type st,
   output pra_pkg::cmd_type    cmd
);
   import pra_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_EVAL  = 6'b001000,
      S_WRITE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready   = (state_ff == S_IDLE);
   assign cmd.clr_en   = (state_ff == S_CLEAR);
   assign cmd.latch    = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.rd       = (state_ff == S_READ);
   assign cmd.ev       = (state_ff == S_EVAL);
   assign cmd.wr       = (state_ff == S_WRITE);
   assign cmd.load_rsp = (state_ff == S_DONE) && !st.rsp_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (st.clr_last) state_in = S_IDLE;
         S_IDLE:  if (req_tvalid) state_in = st.quick ? S_DONE : S_READ;
         S_READ:  state_in = S_EVAL;
         S_EVAL: begin
            unique case (st.ev_next)
               NXT_READ:  state_in = S_READ;
               NXT_WRITE: state_in = S_WRITE;
               NXT_DONE:  state_in = S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_WRITE: if (st.wr_last) state_in = S_DONE;
         S_DONE:  if (!st.rsp_busy) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
      // a new pool size restarts the clearing sweep
      if (st.cfg_wr) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end
endmodule

// File: hw/rtl/pra_datapath.sv
// page record memory, free page count, scan registers and result beat
`timescale 1ns / 1ps
`include "page_run_allocator_top_defines.svh"
module pra_datapath #(
   parameter int MAX_PAGES = pra_pkg::DEF_MAX_PAGES,
   parameter int FLAG_BITS = pra_pkg::DEF_FLAG_BITS,
   localparam int AW = $clog2(MAX_PAGES),
   localparam int CW = $clog2(MAX_PAGES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pra_pkg::cmd_type     cmd,
   output pra_pkg::status_type  st,
   input  logic                 csr_valid,
   input  logic [CW-1:0]        csr_data,
   input  logic [2:0]           in_action,
   input  logic [AW-1:0]        in_page,
   input  logic [CW-1:0]        in_count,
   input  logic                 in_top,
   input  logic [FLAG_BITS-1:0] in_flags,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic                 out_ok,
   output logic [AW-1:0]        out_first,
   output logic [FLAG_BITS-1:0] out_flags,
   output logic [AW-1:0]        out_base,
   output logic [CW-1:0]        out_run,
   output logic                 out_any,
   output logic [CW-1:0]        out_total
);
   import pra_pkg::*;

   localparam int RW = CW + AW + FLAG_BITS;

   logic [RW-1:0] mem [MAX_PAGES];
   logic [RW-1:0] rd_ff;

   logic [CW-1:0]        pc_ff, pc_in, free_ff, free_in, cfg_val;
   logic [AW-1:0]        clr_ff, clr_in, addr_ff, addr_in, wr_addr_ff, wr_addr_in;
   logic [CW-1:0]        rem_ff, rem_in, n_ff, n_in;
   logic [2:0]           act_ff, act_in;
   logic                 top_ff, top_in;
   logic [FLAG_BITS-1:0] flags_ff, flags_in;
   logic [AW-1:0]        run_start_ff, run_start_in, pick_start_ff, pick_start_in;
   logic [CW-1:0]        run_len_ff, run_len_in, pick_len_ff, pick_len_in;
   logic                 pick_found_ff, pick_found_in;
   logic [RW-1:0]        wr_data_ff, wr_data_in;
   logic                 res_ok_ff, res_ok_in, res_any_ff, res_any_in;
   logic [AW-1:0]        res_first_ff, res_first_in, res_base_ff, res_base_in;
   logic [FLAG_BITS-1:0] res_flags_ff, res_flags_in;
   logic [CW-1:0]        res_run_ff, res_run_in;
   logic                 rsp_valid_ff;
   logic [CW-1:0]        total_ff;

   logic [CW-1:0]        rd_len, cur_len, sel_len;
   logic [AW-1:0]        rd_base, cur_start, sel_start, f_top, f_pick;
   logic [FLAG_BITS-1:0] rd_flags;
   logic                 free_pg, last_pg, close_run, fits, in_range;
   logic                 quick;
   next_type             ev_next;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [RW-1:0]        mem_wdata;

   assign rd_len   = rd_ff[CW-1:0];
   assign rd_base  = rd_ff[CW +: AW];
   assign rd_flags = rd_ff[CW + AW +: FLAG_BITS];

   assign mem_we    = cmd.clr_en || cmd.wr;
   assign mem_waddr = cmd.clr_en ? clr_ff : wr_addr_ff;
   assign mem_wdata = cmd.clr_en ? '0 : wr_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.rd) rd_ff <= mem[addr_ff];
   end

   always_comb begin
      if (csr_data == '0)                  cfg_val = CW'(1);
      else if (csr_data > CW'(MAX_PAGES)) cfg_val = CW'(MAX_PAGES);
      else                                 cfg_val = csr_data;
   end

   assign in_range = CW'(in_page) < pc_ff;

   // scan, first fit (last fit from top): free runs are the maximal free spans
   assign free_pg   = (rd_len == '0);
   assign last_pg   = (CW'(addr_ff) == pc_ff - CW'(1));
   assign cur_len   = free_pg ? run_len_ff + CW'(1) : run_len_ff;
   assign cur_start = (free_pg && run_len_ff == '0) ? addr_ff : run_start_ff;
   assign close_run = !free_pg || last_pg;
   assign fits      = close_run && (cur_len >= n_ff);
   assign sel_start = fits ? cur_start : pick_start_ff;
   assign sel_len   = fits ? cur_len : pick_len_ff;
   assign f_top     = AW'(CW'(sel_start) + sel_len - n_ff);
   assign f_pick    = top_ff ? f_top : sel_start;

   always_comb begin
      ev_next = NXT_DONE;
      unique case (act_ff)
         ACT_ALLOC: begin
            if (fits && !top_ff)              ev_next = NXT_WRITE;
            else if (last_pg)                 ev_next = (fits || pick_found_ff) ? NXT_WRITE
                                                                                : NXT_DONE;
            else                              ev_next = NXT_READ;
         end
         ACT_FREE, ACT_SET: ev_next = free_pg ? NXT_DONE : NXT_WRITE;
         ACT_QUERY:         ev_next = NXT_DONE;
         ACT_RANGE: begin
            if (!free_pg || rem_ff == CW'(1) || last_pg) ev_next = NXT_DONE;
            else                                          ev_next = NXT_READ;
         end
         default:           ev_next = NXT_DONE;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;           free_in = free_ff;        clr_in = clr_ff;
      addr_in = addr_ff;       wr_addr_in = wr_addr_ff;  rem_in = rem_ff;
      n_in = n_ff;             act_in = act_ff;          top_in = top_ff;
      flags_in = flags_ff;     run_start_in = run_start_ff; run_len_in = run_len_ff;
      pick_start_in = pick_start_ff; pick_len_in = pick_len_ff;
      pick_found_in = pick_found_ff; wr_data_in = wr_data_ff;
      res_ok_in = res_ok_ff;   res_any_in = res_any_ff;  res_first_in = res_first_ff;
      res_base_in = res_base_ff; res_flags_in = res_flags_ff; res_run_in = res_run_ff;
      quick = 1'b1;

      unique case (in_action)
         ACT_ALLOC:                    quick = (in_count == '0) || (in_count > free_ff);
         ACT_FREE, ACT_SET, ACT_QUERY: quick = !in_range;
         ACT_RANGE:                    quick = (in_count == '0) || !in_range;
         default:                      quick = 1'b1;
      endcase

      if (cmd.clr_en) clr_in = clr_ff + AW'(1);

      if (cmd.latch) begin
         act_in = in_action;  top_in = in_top;  flags_in = in_flags;  n_in = in_count;
         rem_in = in_count;
         addr_in = (in_action == ACT_ALLOC) ? '0 : in_page;
         run_len_in = '0;  run_start_in = '0;  pick_found_in = 1'b0;
         res_ok_in = (in_action == ACT_RANGE);
         res_any_in = 1'b0;  res_first_in = '0;  res_base_in = '0;
         res_flags_in = '0;  res_run_in = '0;
      end

      if (cmd.ev) begin
         unique case (act_ff)
            ACT_ALLOC: begin
               if (ev_next == NXT_WRITE) begin
                  wr_addr_in   = f_pick;
                  rem_in       = n_ff;
                  wr_data_in   = {flags_ff, f_pick, n_ff};
                  free_in      = free_ff - n_ff;
                  res_ok_in    = 1'b1;
                  res_first_in = f_pick;
               end else if (ev_next == NXT_READ) begin
                  addr_in      = addr_ff + AW'(1);
                  run_len_in   = close_run ? '0 : cur_len;
                  run_start_in = cur_start;
                  if (fits) begin
                     pick_found_in = 1'b1;
                     pick_start_in = cur_start;
                     pick_len_in   = cur_len;
                  end
               end
            end
            ACT_FREE: begin
               if (!free_pg) begin
                  wr_addr_in = rd_base;
                  rem_in     = rd_len;
                  wr_data_in = '0;
                  free_in    = free_ff + rd_len;
                  res_ok_in  = 1'b1;
               end
            end
            ACT_SET: begin
               if (!free_pg) begin
                  wr_addr_in = addr_ff;
                  rem_in     = CW'(1);
                  wr_data_in = {flags_ff, rd_base, rd_len};
                  res_ok_in  = 1'b1;
               end
            end
            ACT_QUERY: begin
               if (!free_pg) begin
                  res_ok_in    = 1'b1;
                  res_flags_in = rd_flags;
                  res_base_in  = rd_base;
                  res_run_in   = rd_len;
               end
            end
            ACT_RANGE: begin
               if (!free_pg) res_any_in = 1'b1;
               addr_in = addr_ff + AW'(1);
               rem_in  = rem_ff - CW'(1);
            end
            default: ;
         endcase
      end

      if (cmd.wr) begin
         wr_addr_in = wr_addr_ff + AW'(1);
         rem_in     = rem_ff - CW'(1);
      end

      if (csr_valid) begin
         pc_in   = cfg_val;
         free_in = cfg_val;
         clr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= CW'(MAX_PAGES);
         free_ff      <= CW'(MAX_PAGES);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         free_ff <= free_in;
         clr_ff  <= clr_in;
         if (cmd.load_rsp)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      addr_ff <= addr_in;  wr_addr_ff <= wr_addr_in;  rem_ff <= rem_in;  n_ff <= n_in;
      act_ff <= act_in;  top_ff <= top_in;  flags_ff <= flags_in;
      run_start_ff <= run_start_in;  run_len_ff <= run_len_in;
      pick_start_ff <= pick_start_in;  pick_len_ff <= pick_len_in;
      pick_found_ff <= pick_found_in;  wr_data_ff <= wr_data_in;
      res_ok_ff <= res_ok_in;  res_any_ff <= res_any_in;  res_first_ff <= res_first_in;
      res_base_ff <= res_base_in;  res_flags_ff <= res_flags_in;  res_run_ff <= res_run_in;
      if (cmd.load_rsp) begin
         out_ok    <= res_ok_ff;
         out_first <= res_first_ff;
         out_flags <= res_flags_ff;
         out_base  <= res_base_ff;
         out_run   <= res_run_ff;
         out_any   <= res_any_ff;
         total_ff  <= pc_ff - free_ff;
      end
   end

   assign out_total    = total_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign st.cfg_wr    = csr_valid;
   assign st.clr_last  = (clr_ff == AW'(MAX_PAGES - 1));
   assign st.quick     = quick;
   assign st.ev_next   = ev_next;
   assign st.wr_last   = (rem_ff == CW'(1));
   assign st.rsp_busy  = rsp_valid_ff && !rsp_tready;

   `PRA_ASSERT(a_free_within_pool, clock, reset, free_ff <= pc_ff, "free pages exceed pool")
   `PRA_ASSERT(a_write_in_pool, clock, reset, cmd.wr |-> CW'(wr_addr_ff) < pc_ff, "write past pool")
   `PRA_ASSERT(a_cfg_refills, clock, reset, csr_valid |=> free_ff == pc_ff, "pool not refilled")
   `PRA_ASSERT_ANY(a_reset_pool, clock, reset |=> pc_ff == CW'(MAX_PAGES) && free_ff == pc_ff, "bad reset pool")
endmodule

// File: hw/rtl/page_run_allocator_top.sv
// page run allocator: request beats in, one response beat per request
// rejected or out-of-pool requests skip the memory; query reads the page, set rewrites it;
// free clears its run; allocate reads page by page up to the fitting run (whole pool for
// top), then n writes; range check reads each page examined; all work goes through the
// single record memory; reset and csr writes clear all records, no requests taken then
`timescale 1ns / 1ps
module page_run_allocator_top #(
   parameter int MAX_PAGES = pra_pkg::DEF_MAX_PAGES,
   parameter int FLAG_BITS = pra_pkg::DEF_FLAG_BITS,
   localparam int AW = $clog2(MAX_PAGES),
   localparam int CW = $clog2(MAX_PAGES + 1),
   localparam int REQ_DW = AW + CW + 1 + FLAG_BITS,
   localparam int REQ_W = ((REQ_DW + 7) / 8) * 8,
   localparam int RSP_DW = 1 + AW + FLAG_BITS + AW + CW + 1 + CW,
   localparam int RSP_W = ((RSP_DW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // page, count, from_top, flag_word
   input  logic [2:0]       req_tuser,  // action
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // ok, first_page, flags_out, base_page, run_pages,
                                        // any_allocated, total_allocated
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CW-1:0]    csr_data
);
   import pra_pkg::*;

   cmd_type    cmd;
   status_type st;

   logic                 out_ok, out_any;
   logic [AW-1:0]        out_first, out_base;
   logic [FLAG_BITS-1:0] out_flags;
   logic [CW-1:0]        out_run, out_total;

   assign csr_ready = 1'b1;

   pra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pra_datapath #(
      .MAX_PAGES (MAX_PAGES),
      .FLAG_BITS (FLAG_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .in_action  (req_tuser),
      .in_page    (req_tdata[AW-1:0]),
      .in_count   (req_tdata[AW +: CW]),
      .in_top     (req_tdata[AW + CW]),
      .in_flags   (req_tdata[AW + CW + 1 +: FLAG_BITS]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .out_ok     (out_ok),
      .out_first  (out_first),
      .out_flags  (out_flags),
      .out_base   (out_base),
      .out_run    (out_run),
      .out_any    (out_any),
      .out_total  (out_total)
   );

   assign rsp_tdata = RSP_W'({out_total, out_any, out_run, out_base, out_flags,
                              out_first, out_ok});
endmodule

// File: test/tb_page_run_allocator_top.sv
// testbench for the page run allocator: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module tb_page_run_allocator_top;
   import pra_pkg::*;

   localparam int NP = 1024;
   localparam int REQ_W = 56;
   localparam int RSP_W = 80;

   typedef struct packed {
      logic        ok;
      logic [9:0]  first_page;
      logic [31:0] flags_out;
      logic [9:0]  base_page;
      logic [10:0] run_pages;
      logic        any_allocated;
      logic [10:0] total_allocated;
   } resp_t;

   typedef struct {
      logic [2:0]  action;
      logic [9:0]  page;
      logic [10:0] count;
      logic        from_top;
      logic [31:0] flag_word;
   } req_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [10:0] csr_data = '0;

   page_run_allocator_top uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // allocator mirror
   int unsigned pool_size;
   int unsigned run_len_of [NP];
   int unsigned base_of [NP];
   logic [31:0] flags_of [NP];
   int unsigned run_start [$];
   int unsigned run_size [$];
   int unsigned free_total;

   req_t pending_reqs [$];
   resp_t expected_resps [$];
   bit failed = 0;
   bit hold_rsp = 0;
   bit no_idle = 0;
   int stall_left = 0;
   longint cycles = 0;

   function automatic void pool_reinit(int unsigned v);
      if (v == 0) v = 1;
      if (v > NP) v = NP;
      pool_size = v;
      foreach (run_len_of[i]) begin
         run_len_of[i] = 0;
         base_of[i] = 0;
         flags_of[i] = 0;
      end
      run_start = {0};
      run_size = {v};
      free_total = v;
   endfunction

   function automatic bit live(int unsigned p);
      return p < pool_size && run_len_of[p] != 0;
   endfunction

   function automatic resp_t predict_response(req_t r);
      resp_t o;
      int pick;
      int unsigned f, b, l, pos;
      bit jp, jn;
      o = '0;
      case (r.action)
         ACT_ALLOC: begin
            pick = -1;
            if (r.count != 0 && r.count <= free_total)
               foreach (run_size[i])
                  if (run_size[i] >= r.count) begin
                     pick = i;
                     if (!r.from_top) break;
                  end
            if (pick >= 0) begin
               f = r.from_top ? run_start[pick] + run_size[pick] - r.count : run_start[pick];
               if (run_size[pick] == r.count) begin
                  run_start.delete(pick);
                  run_size.delete(pick);
               end else begin
                  if (!r.from_top) run_start[pick] += r.count;
                  run_size[pick] -= r.count;
               end
               for (int unsigned q = f; q < f + r.count; q++) begin
                  run_len_of[q] = r.count;
                  base_of[q] = f;
                  flags_of[q] = r.flag_word;
               end
               free_total -= r.count;
               o.ok = 1;
               o.first_page = 10'(f);
            end
         end
         ACT_FREE: if (live(r.page)) begin
            b = base_of[r.page];
            l = run_len_of[r.page];
            for (int unsigned q = b; q < b + l; q++) begin
               run_len_of[q] = 0;
               base_of[q] = 0;
               flags_of[q] = 0;
            end
            pos = 0;
            while (pos < run_start.size() && run_start[pos] < b) pos++;
            jp = pos > 0 && run_start[pos-1] + run_size[pos-1] == b;
            jn = pos < run_start.size() && b + l == run_start[pos];
            if (jp && jn) begin
               run_size[pos-1] += l + run_size[pos];
               run_start.delete(pos);
               run_size.delete(pos);
            end else if (jp) run_size[pos-1] += l;
            else if (jn) begin
               run_start[pos] = b;
               run_size[pos] += l;
            end else begin
               run_start.insert(pos, b);
               run_size.insert(pos, l);
            end
            free_total += l;
            o.ok = 1;
         end
         ACT_SET: if (live(r.page)) begin
            flags_of[r.page] = r.flag_word;
            o.ok = 1;
         end
         ACT_QUERY: if (live(r.page)) begin
            o.ok = 1;
            o.flags_out = flags_of[r.page];
            o.base_page = 10'(base_of[r.page]);
            o.run_pages = 11'(run_len_of[r.page]);
         end
         ACT_RANGE: begin
            o.ok = 1;
            for (int unsigned i = 0; i < r.count; i++) begin
               if (r.page + i >= pool_size) break;
               if (run_len_of[r.page + i] != 0) begin
                  o.any_allocated = 1;
                  break;
               end
            end
         end
         default: ;
      endcase
      o.total_allocated = 11'(pool_size - free_total);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_resps.push_back(predict_response(pending_reqs.pop_front()));
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_reqs.size() > (req_tvalid && req_tready ? 0 : 0) &&
                (no_idle || $urandom_range(99) >= 34)) begin
               req_tvalid <= 1;
               req_tdata <= {2'd0, pending_reqs[0].flag_word, pending_reqs[0].from_top,
                             pending_reqs[0].count, pending_reqs[0].page};
               req_tuser <= pending_reqs[0].action;
            end else req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      resp_t got, exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[10:1], rsp_tdata[42:11], rsp_tdata[52:43],
                   rsp_tdata[63:53], rsp_tdata[64], rsp_tdata[75:65]};
            if (expected_resps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               failed = 1;
            end else begin
               exp_r = expected_resps.pop_front();
               if (got.ok != exp_r.ok || got.first_page != exp_r.first_page ||
                   got.flags_out != exp_r.flags_out || got.base_page != exp_r.base_page ||
                   got.run_pages != exp_r.run_pages ||
                   got.any_allocated != exp_r.any_allocated ||
                   got.total_allocated != exp_r.total_allocated) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                  failed = 1;
               end
            end
         end
         rsp_tready <= !hold_rsp && stall_left <= 1 && (no_idle || $urandom_range(99) >= 34);
      end
   end

   // receiver hold-off counter
   always @(posedge clock)
      if (stall_left > 0) stall_left <= stall_left - 1;

   always @(posedge clock)
      if (cycles > 64'd3000000) begin
         $display("Test completed with failures");
         $finish;
      end

   task automatic push_req(int unsigned a, int unsigned p, int unsigned c, int unsigned t,
                           logic [31:0] fw);
      req_t r;
      r.action = 3'(a);
      r.page = 10'(p);
      r.count = 11'(c);
      r.from_top = 1'(t);
      r.flag_word = fw;
      pending_reqs.push_back(r);
   endtask

   task automatic drain;
      while (pending_reqs.size() != 0 || req_tvalid || expected_resps.size() != 0)
         @(posedge clock);
      repeat (4200) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [10:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      pool_reinit(v);
   endtask

   // mostly well-formed traffic over a small pool with small counts
   task automatic random_phase(int n);
      int unsigned sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 35)
            push_req(ACT_ALLOC, 0, ($urandom_range(9) == 0) ? $urandom_range(pool_size + 2)
                     : $urandom_range(1, 8), $urandom_range(1), $urandom);
         else if (sel < 60) push_req(ACT_FREE, $urandom_range(pool_size), 0, 0, $urandom);
         else if (sel < 72)
            push_req(ACT_SET, $urandom_range(pool_size), 0, $urandom_range(1), $urandom);
         else if (sel < 86) push_req(ACT_QUERY, $urandom_range(pool_size), 0, 0, 0);
         else if (sel < 96)
            push_req(ACT_RANGE, $urandom_range(pool_size), $urandom_range(12), 0, 0);
         else
            push_req($urandom_range(5, 7), $urandom_range(1023), $urandom_range(2047),
                     $urandom_range(1), $urandom);
      end
   endtask

   initial begin
      pool_reinit(NP);
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed: extremes and special cases at the full pool
      push_req(ACT_ALLOC, 0, 0, 0, 32'hffff_ffff);
      push_req(ACT_ALLOC, 0, 1025, 0, 0);
      push_req(ACT_ALLOC, 1023, 3, 0, 32'hdead_beef);
      push_req(ACT_ALLOC, 0, 2, 1, 32'h1234_5678);
      push_req(ACT_QUERY, 1023, 0, 0, 0);
      push_req(ACT_QUERY, 1, 0, 0, 0);
      push_req(ACT_SET, 0, 0, 0, 32'hffff_ffff);
      push_req(ACT_SET, 500, 0, 0, 32'h5555_aaaa);
      push_req(ACT_RANGE, 3, 1000, 0, 0);
      push_req(ACT_RANGE, 1020, 2047, 0, 0);
      push_req(ACT_RANGE, 0, 0, 0, 0);
      push_req(ACT_FREE, 600, 0, 0, 0);
      push_req(ACT_FREE, 1, 0, 0, 0);
      push_req(ACT_FREE, 1022, 0, 0, 0);
      push_req(3'd5, 1023, 2047, 1, 32'hffff_ffff);
      push_req(3'd7, 0, 0, 0, 0);
      push_req(ACT_ALLOC, 0, 1024, 0, 0);
      push_req(ACT_FREE, 512, 0, 0, 0);
      drain();
      write_pool_size(11'd0);
      push_req(ACT_ALLOC, 0, 1, 1, 32'h8000_0001);
      push_req(ACT_QUERY, 0, 0, 0, 0);
      push_req(ACT_FREE, 0, 0, 0, 0);
      push_req(ACT_QUERY, 5, 0, 0, 0);
      drain();
      write_pool_size(11'd2047);
      push_req(ACT_ALLOC, 0, 1024, 1, 32'h0f0f_0f0f);
      drain();
      write_pool_size(11'd48);
      random_phase(300);
      // long receiver hold-off while requests keep coming
      stall_left <= 400;
      drain();
      random_phase(40);
      no_idle = 1;
      drain();
      no_idle = 0;
      write_pool_size(11'd17);
      random_phase(250);
      drain();
      write_pool_size(11'd64);
      random_phase(220);
      drain();
      if (!failed) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pra_pkg.sv
hw/rtl/pra_ctrl.sv
hw/rtl/pra_datapath.sv
hw/rtl/page_run_allocator_top.sv
test/tb_page_run_allocator_top.sv
